### hdl/prts_pkg.sv
package prts_pkg;

    localparam int TaskIdW = 4;
    localparam int PrioW = 3;
    localparam int TickW = 64;
    localparam int WokenW = 5;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_SUSPEND  = 3'd2,
        OP_READY    = 3'd3,
        OP_DELAY    = 3'd4,
        OP_TICK     = 3'd5,
        OP_BAD6     = 3'd6,
        OP_BAD7     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        PLACE_NONE  = 2'd0,
        PLACE_READY = 2'd1,
        PLACE_TIMER = 2'd2,
        PLACE_RSVD  = 2'd3
    } t_place;

    typedef struct packed {
        t_op                op;
        logic [TaskIdW-1:0] task_id;
        logic               use_running;
        logic [PrioW-1:0]   prio;
        logic [TickW-1:0]   delay_ticks;
    } t_req;

    typedef struct packed {
        logic [TaskIdW-1:0] running_task;
        logic               running_idle;
        logic [WokenW-1:0]  woken_count;
        logic               status;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_DISPATCH,
        S_APP_RD,
        S_APP_WR,
        S_UNL_RD,
        S_UNL_WR,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_SCH_SCAN,
        S_SCH_RD,
        S_SCH_CHK,
        S_TICK_RD,
        S_TICK_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       we;
        logic [6:0] waddr;
        logic [6:0] wdata;
        logic [6:0] raddr;
    } t_lnk_cmd;

endpackage

### hdl/prts_link_mem.sv
module prts_link_mem
    import prts_pkg::*;
#(
    parameter int Depth = 25,
    parameter int AddrW = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [AddrW-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [AddrW-1:0] o_rdata
);
    logic [AddrW-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### hdl/prts_wake_mem.sv
module prts_wake_mem
    import prts_pkg::*;
#(
    parameter int Depth = 16,
    parameter int AddrW = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [TickW-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [TickW-1:0] o_rdata
);
    logic [TickW-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### hdl/priority_round_robin_task_scheduler_top.sv
// Flow: an ignored request goes straight to the result strobe; make ready on a sleeping task
// first unlinks it from the timer list, delay walks the timer list one node at a time, and a
// tick appends each woken task in turn.
// Throughput: one request at a time; busy is high from the accept until the result strobe.
// Reset: synchronous active-low; then a clearing pass initializes the link
// memories with busy high. o_done strobes each result for one cycle; the receiver cannot stall.
module priority_round_robin_task_scheduler_top
    import prts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int PRIORITY_LEVELS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam int Nodes = MAX_TASKS + PRIORITY_LEVELS + 1;
    localparam int NW = $clog2(Nodes);
    localparam int TW = $clog2(MAX_TASKS);
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [NW-1:0] TimerSent = NW'(MAX_TASKS + PRIORITY_LEVELS);
    localparam logic [NW-1:0] IdleTask = NW'(MAX_TASKS);

    // level state and task attributes are small register files
    logic [NW-1:0] r_cursor [PRIORITY_LEVELS];
    logic [CW-1:0] r_lcount [PRIORITY_LEVELS];
    logic [LW-1:0] r_tlevel [MAX_TASKS];
    t_place        r_tplace [MAX_TASKS];
    logic [NW-1:0] r_ttail, r_cur;
    logic [CW-1:0] r_tcount;
    logic [TickW-1:0] r_now;
    logic [TickW-1:0] r_wk;

    t_state r_state, n_state;
    t_req   r_req;
    logic [NW-1:0] r_t, r_a, r_b, r_c, r_clr;
    logic [2:0] r_sub;
    logic [LW-1:0] r_lv;
    logic [1:0] r_guard;
    logic [WokenW-1:0] r_woken;
    logic r_status;

    // link memories: next and prev
    logic nx_we, pv_we;
    logic [NW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd;
    logic wk_we;
    logic [TW-1:0] wk_wa, wk_ra;
    logic [TickW-1:0] wk_wd, wk_rd;

    prts_link_mem #(.Depth(Nodes), .AddrW(NW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    prts_link_mem #(.Depth(Nodes), .AddrW(NW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    prts_wake_mem #(.Depth(MAX_TASKS), .AddrW(TW)) u_wake (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_wa), .i_wdata(wk_wd),
        .i_raddr(wk_ra), .o_rdata(wk_rd));

    logic [NW-1:0] tsel;
    logic tvalid;
    logic [TW-1:0] tix;
    logic [LW-1:0] plv;
    logic [NW-1:0] lsent;
    t_place tplace_sel;
    logic disp_bad, ins_stop, sch_hop, tick_due;
    assign tsel = r_req.use_running ? r_cur : NW'(r_req.task_id);
    assign tvalid = tsel < NW'(MAX_TASKS);
    assign tix = r_t[TW-1:0];
    assign plv = (int'(r_req.prio) >= PRIORITY_LEVELS) ? LW'(PRIORITY_LEVELS - 1)
                                                       : LW'(r_req.prio);
    assign lsent = NW'(MAX_TASKS) + NW'(r_tlevel[tix]);
    assign tplace_sel = r_tplace[tsel[TW-1:0]];
    assign ins_stop = (r_c >= NW'(MAX_TASKS)) || (r_wk <= wk_rd);
    assign sch_hop = (nx_rd >= NW'(MAX_TASKS)) && (r_guard != 2'd2);
    assign tick_due = (r_tcount != '0) && (r_ttail < NW'(MAX_TASKS)) && (wk_rd <= r_now);

    assign busy = (r_state != S_IDLE);

    always_comb begin
        unique case (r_req.op)
            OP_CREATE:            disp_bad = !tvalid || tplace_sel != PLACE_NONE;
            OP_SUSPEND, OP_DELAY: disp_bad = !tvalid || tplace_sel != PLACE_READY;
            OP_READY:             disp_bad = !tvalid || tplace_sel == PLACE_READY;
            OP_SCHEDULE, OP_TICK: disp_bad = 1'b0;
            default:              disp_bad = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
        wk_we = 1'b0; wk_wa = tix; wk_wd = r_req.delay_ticks + r_now; wk_ra = tix;
        unique case (r_state)
            S_CLEAR: begin
                nx_we = 1'b1; nx_wa = r_clr; nx_wd = r_clr;
                pv_we = 1'b1; pv_wa = r_clr; pv_wd = r_clr;
                if (r_clr == TimerSent) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                if (!disp_bad) begin
                    unique case (r_req.op)
                        OP_CREATE:            n_state = S_APP_RD;
                        OP_SCHEDULE:          n_state = S_SCH_SCAN;
                        OP_SUSPEND, OP_DELAY: n_state = S_UNL_RD;
                        OP_READY: begin
                            n_state = (tplace_sel == PLACE_TIMER) ? S_UNL_RD : S_APP_RD;
                        end
                        OP_TICK:              n_state = S_TICK_RD;
                        default:              n_state = S_DONE;
                    endcase
                end
                if (r_req.op == OP_DELAY) begin
                    wk_we = !disp_bad;
                    wk_wa = tsel[TW-1:0];
                end
            end
            S_APP_RD: begin
                pv_ra = lsent;
                n_state = S_APP_WR;
            end
            S_APP_WR: begin
                // sub 0: next[a]=t, prev[s]=t ; sub 1: next[t]=s, prev[t]=a
                nx_we = 1'b1; pv_we = 1'b1;
                if (r_sub == 3'd0) begin
                    nx_wa = pv_rd; nx_wd = r_t; pv_wa = lsent; pv_wd = r_t;
                end else begin
                    nx_wa = r_t; nx_wd = lsent; pv_wa = r_t; pv_wd = r_a;
                    n_state = (r_req.op == OP_TICK) ? S_TICK_RD : S_DONE;
                end
            end
            S_UNL_RD: begin
                nx_ra = r_t; pv_ra = r_t;
                n_state = S_UNL_WR;
            end
            S_UNL_WR: begin
                nx_we = 1'b1; pv_we = 1'b1;
                if (r_sub == 3'd0) begin
                    nx_wa = pv_rd; nx_wd = nx_rd; pv_wa = nx_rd; pv_wd = pv_rd;
                end else begin
                    nx_wa = r_t; nx_wd = r_t; pv_wa = r_t; pv_wd = r_t;
                    unique case (r_req.op)
                        OP_SUSPEND: n_state = S_SCH_SCAN;
                        OP_DELAY:   n_state = S_INS_RD;
                        default:    n_state = S_APP_RD;
                    endcase
                end
            end
            S_INS_RD: begin
                pv_ra = r_c; wk_ra = r_c[TW-1:0]; nx_ra = r_c;
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                // stop at sentinel or when new wake time <= wake[c]
                n_state = ins_stop ? S_INS_WR : S_INS_RD;
            end
            S_INS_WR: begin
                nx_we = 1'b1; pv_we = 1'b1;
                if (r_sub == 3'd0) begin
                    nx_wa = r_t; nx_wd = r_b; pv_wa = r_b; pv_wd = r_t;
                end else begin
                    nx_wa = r_c; nx_wd = r_t; pv_wa = r_t; pv_wd = r_c;
                    n_state = S_SCH_SCAN;
                end
            end
            S_SCH_SCAN: begin
                if (r_lcount[r_lv] != '0) begin
                    n_state = S_SCH_RD;
                end else if (r_lv == LW'(PRIORITY_LEVELS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_SCH_RD: begin
                nx_ra = r_c;
                n_state = S_SCH_CHK;
            end
            S_SCH_CHK: begin
                n_state = sch_hop ? S_SCH_RD : S_DONE;
            end
            S_TICK_RD: begin
                wk_ra = r_ttail[TW-1:0];
                n_state = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                n_state = tick_due ? S_UNL_RD : S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_done <= 1'b0;
            r_clr <= '0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_cursor[i] <= NW'(MAX_TASKS + i);
                r_lcount[i] <= '0;
            end
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_tlevel[i] <= '0;
                r_tplace[i] <= PLACE_NONE;
            end
            r_ttail <= TimerSent;
            r_tcount <= '0;
            r_now <= '0;
            r_cur <= IdleTask;
            r_sub <= '0;
        end else begin
            r_state <= n_state;
            o_done <= (r_state == S_DONE);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (start) r_req <= i_req;
                end
                S_DISPATCH: begin
                    r_t <= tsel;
                    r_status <= disp_bad;
                    r_woken <= '0;
                    r_sub <= '0;
                    r_lv <= '0;
                    r_wk <= wk_wd;
                    if (r_req.op == OP_CREATE && !disp_bad)
                        r_tlevel[tsel[TW-1:0]] <= plv;
                    if (r_req.op == OP_TICK)
                        r_now <= r_now + 1'b1;
                end
                S_APP_RD: begin
                    r_sub <= '0;
                end
                S_APP_WR: begin
                    if (r_sub == 3'd0) begin
                        r_a <= pv_rd;
                        r_sub <= 3'd1;
                    end else begin
                        r_lcount[r_tlevel[tix]] <= r_lcount[r_tlevel[tix]] + 1'b1;
                        r_tplace[tix] <= PLACE_READY;
                        if (r_req.op == OP_TICK) r_woken <= r_woken + 1'b1;
                    end
                end
                S_UNL_RD: begin
                    r_sub <= '0;
                end
                S_UNL_WR: begin
                    if (r_sub == 3'd0) begin
                        r_sub <= 3'd1;
                        if (r_tplace[tix] == PLACE_READY) begin
                            if (r_cursor[r_tlevel[tix]] == r_t)
                                r_cursor[r_tlevel[tix]] <= pv_rd;
                            if (r_lcount[r_tlevel[tix]] != '0)
                                r_lcount[r_tlevel[tix]] <= r_lcount[r_tlevel[tix]] - 1'b1;
                        end else begin
                            if (r_ttail == r_t) r_ttail <= pv_rd;
                            if (r_tcount != '0) r_tcount <= r_tcount - 1'b1;
                        end
                    end else begin
                        r_tplace[tix] <= PLACE_NONE;
                        r_sub <= '0;
                        r_lv <= '0;
                        r_c <= r_ttail;
                        r_guard <= '0;
                    end
                end
                S_INS_CMP: begin
                    if (ins_stop) begin
                        r_b <= nx_rd;
                        r_sub <= '0;
                    end else begin
                        r_c <= pv_rd;
                    end
                end
                S_INS_WR: begin
                    if (r_sub == 3'd0) begin
                        r_sub <= 3'd1;
                    end else begin
                        if (r_c == r_ttail) r_ttail <= r_t;
                        r_tcount <= r_tcount + 1'b1;
                        r_tplace[tix] <= PLACE_TIMER;
                        r_lv <= '0;
                    end
                end
                S_SCH_SCAN: begin
                    if (r_lcount[r_lv] != '0) begin
                        r_c <= r_cursor[r_lv];
                        r_guard <= '0;
                    end else if (r_lv == LW'(PRIORITY_LEVELS - 1)) begin
                        r_cur <= IdleTask;
                    end else begin
                        r_lv <= r_lv + 1'b1;
                    end
                end
                S_SCH_CHK: begin
                    if (sch_hop) begin
                        r_c <= nx_rd;
                        r_guard <= r_guard + 1'b1;
                    end else begin
                        r_cursor[r_lv] <= nx_rd;
                        r_cur <= (nx_rd < NW'(MAX_TASKS)) ? nx_rd : IdleTask;
                    end
                end
                S_TICK_CHK: begin
                    if (tick_due) r_t <= r_ttail;
                end
                S_DONE: begin
                    o_rsp.running_task <= (r_cur < NW'(MAX_TASKS)) ? TaskIdW'(r_cur) : '0;
                    o_rsp.running_idle <= !(r_cur < NW'(MAX_TASKS));
                    o_rsp.woken_count <= r_woken;
                    o_rsp.status <= r_status;
                end
                default: ;
            endcase
        end
    end
endmodule

### tb/sv/tb_priority_round_robin_task_scheduler_top.sv
module tb_priority_round_robin_task_scheduler_top;
    import prts_pkg::*;

    localparam int NTASK = 16;
    localparam int NLVL = 8;
    localparam int NNODE = NTASK + NLVL + 1;
    localparam int TSENT = NTASK + NLVL;
    localparam int IDLE_ID = NTASK;
    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_rsp o_rsp;

    priority_round_robin_task_scheduler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // scheduler predictor plus queue of expected responses
    class sched_scoreboard;
        int nxt[NNODE];
        int prv[NNODE];
        int cursor[NLVL];
        int lcount[NLVL];
        int tlevel[NTASK];
        t_place place[NTASK];
        logic [TickW-1:0] wake[NTASK];
        int ttail;
        int tcount;
        logic [TickW-1:0] now;
        int cur;
        t_rsp pending[$];
        int errors;

        function void clear();
            for (int i = 0; i < NNODE; i++) begin
                nxt[i] = i;
                prv[i] = i;
            end
            for (int i = 0; i < NLVL; i++) begin
                cursor[i] = NTASK + i;
                lcount[i] = 0;
            end
            for (int i = 0; i < NTASK; i++) begin
                tlevel[i] = 0;
                place[i] = PLACE_NONE;
                wake[i] = '0;
            end
            ttail = TSENT;
            tcount = 0;
            now = '0;
            cur = IDLE_ID;
            pending.delete();
            errors = 0;
        endfunction

        function void unlink(int n);
            int p;
            int q;
            p = prv[n];
            q = nxt[n];
            nxt[p] = q;
            prv[q] = p;
            nxt[n] = n;
            prv[n] = n;
        endfunction

        function void append(int t);
            int s;
            int a;
            s = NTASK + tlevel[t];
            a = prv[s];
            nxt[a] = t;
            nxt[t] = s;
            prv[s] = t;
            prv[t] = a;
            lcount[tlevel[t]]++;
            place[t] = PLACE_READY;
        endfunction

        function void ready_out(int t);
            int lv;
            lv = tlevel[t];
            if (cursor[lv] == t) cursor[lv] = prv[t];
            unlink(t);
            if (lcount[lv] > 0) lcount[lv]--;
            place[t] = PLACE_NONE;
        endfunction

        function void sleep_out(int t);
            if (ttail == t) ttail = prv[t];
            unlink(t);
            if (tcount > 0) tcount--;
            place[t] = PLACE_NONE;
        endfunction

        function void sleep_in(int t);
            int c;
            int nx;
            c = ttail;
            for (int g = 0; g <= NTASK; g++) begin
                if (c == TSENT || c >= NTASK || wake[t] <= wake[c]) break;
                c = prv[c];
            end
            nx = nxt[c];
            nxt[t] = nx;
            prv[nx] = t;
            prv[t] = c;
            nxt[c] = t;
            if (c == ttail) ttail = t;
            tcount++;
            place[t] = PLACE_TIMER;
        endfunction

        function void pick();
            int c;
            for (int lv = 0; lv < NLVL; lv++) begin
                if (lcount[lv] > 0) begin
                    c = nxt[cursor[lv]];
                    for (int g = 0; g < 2 && c >= NTASK; g++) c = nxt[c];
                    cursor[lv] = c;
                    cur = (c < NTASK) ? c : IDLE_ID;
                    return;
                end
            end
            cur = IDLE_ID;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            int t;
            bit ok;
            int woken;
            bit st;
            t = r.use_running ? cur : int'(r.task_id);
            ok = t < NTASK;
            woken = 0;
            st = 1'b0;
            case (r.op)
                OP_CREATE: begin
                    if (!ok || place[t] != PLACE_NONE) st = 1'b1;
                    else begin
                        tlevel[t] = r.prio;
                        append(t);
                    end
                end
                OP_SCHEDULE: pick();
                OP_SUSPEND: begin
                    if (!ok || place[t] != PLACE_READY) st = 1'b1;
                    else begin
                        ready_out(t);
                        pick();
                    end
                end
                OP_READY: begin
                    if (!ok || place[t] == PLACE_READY) st = 1'b1;
                    else begin
                        if (place[t] == PLACE_TIMER) sleep_out(t);
                        append(t);
                    end
                end
                OP_DELAY: begin
                    if (!ok || place[t] != PLACE_READY) st = 1'b1;
                    else begin
                        wake[t] = r.delay_ticks + now;
                        ready_out(t);
                        sleep_in(t);
                        pick();
                    end
                end
                OP_TICK: begin
                    int w;
                    now = now + 1;
                    while (tcount > 0 && ttail < NTASK && wake[ttail] <= now) begin
                        w = ttail;
                        sleep_out(w);
                        append(w);
                        woken++;
                    end
                end
                default: st = 1'b1;
            endcase
            e.running_task = (cur < NTASK) ? cur[TaskIdW-1:0] : '0;
            e.running_idle = (cur >= NTASK);
            e.woken_count = woken[WokenW-1:0];
            e.status = st;
            pending.push_back(e);
        endfunction

        function void check_response(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                $error("response with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.running_task !== e.running_task) begin
                $error("running_task exp %0d got %0d", e.running_task, a.running_task);
                errors++;
            end
            if (a.running_idle !== e.running_idle) begin
                $error("running_idle exp %0d got %0d", e.running_idle, a.running_idle);
                errors++;
            end
            if (a.woken_count !== e.woken_count) begin
                $error("woken_count exp %0d got %0d", e.woken_count, a.woken_count);
                errors++;
            end
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status);
                errors++;
            end
        endfunction
    endclass

    sched_scoreboard sb;
    int gap_pct = 0;
    int stall_cycles = 0;
    bit watchdog_hit = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_response(o_rsp);
            if ((start && !busy) || o_done) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT && !watchdog_hit) begin
            watchdog_hit = 1'b1;
            $display("priority_round_robin_task_scheduler_top regression: fail");
            $finish;
        end
    end

    // start stays high after the accept; the block is busy then, and the next
    // request or a drain replaces it
    task automatic send_request(t_req r);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
    endtask

    function automatic t_req make_req(t_op op, int id, bit run, int pr,
                                      logic [TickW-1:0] d);
        t_req r;
        r.op = op;
        r.task_id = id[TaskIdW-1:0];
        r.use_running = run;
        r.prio = pr[PrioW-1:0];
        r.delay_ticks = d;
        return r;
    endfunction

    function automatic logic [TickW-1:0] rand_delay();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom};
            3: return {$urandom, $urandom} | 64'h8000_0000_0000_0000;
            default: return 64'($urandom_range(6));
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int k;
        k = $urandom_range(99);
        r = make_req(OP_TICK, $urandom_range(15), $urandom_range(3) == 0,
                     $urandom_range(7), rand_delay());
        if (k < 15) r.op = OP_CREATE;
        else if (k < 35) r.op = OP_SCHEDULE;
        else if (k < 45) r.op = OP_SUSPEND;
        else if (k < 57) r.op = OP_READY;
        else if (k < 70) r.op = OP_DELAY;
        else if (k < 97) r.op = OP_TICK;
        else r.op = t_op'($urandom_range(7, 6));
        return r;
    endfunction

    task automatic wait_drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_request(make_req(OP_SCHEDULE, 0, 1'b0, 0, '0));
        send_request(make_req(OP_SUSPEND, 0, 1'b1, 0, '0));
        send_request(make_req(OP_CREATE, 15, 1'b0, 7, '0));
        send_request(make_req(OP_CREATE, 0, 1'b0, 0, '1));
        send_request(make_req(OP_CREATE, 1, 1'b0, 0, '0));
        send_request(make_req(OP_CREATE, 1, 1'b0, 3, '0));
        send_request(make_req(OP_SCHEDULE, 0, 1'b0, 0, '0));
        send_request(make_req(OP_SCHEDULE, 0, 1'b0, 0, '0));
        send_request(make_req(OP_READY, 0, 1'b0, 0, '0));
        send_request(make_req(OP_DELAY, 0, 1'b1, 0, 64'd2));
        send_request(make_req(OP_DELAY, 1, 1'b0, 0, 64'd2));
        send_request(make_req(OP_DELAY, 15, 1'b0, 0, '1));
        send_request(make_req(OP_DELAY, 3, 1'b0, 0, 64'd1));
        send_request(make_req(OP_SUSPEND, 1, 1'b0, 0, '0));
        send_request(make_req(OP_TICK, 0, 1'b0, 0, '0));
        send_request(make_req(OP_TICK, 0, 1'b0, 0, '0));
        send_request(make_req(OP_READY, 15, 1'b0, 0, '0));
        send_request(make_req(OP_SUSPEND, 0, 1'b1, 0, '0));
        send_request(make_req(OP_BAD6, 5, 1'b0, 0, '0));
        send_request(make_req(OP_BAD7, 5, 1'b1, 7, '1));
        send_request(make_req(OP_READY, 6, 1'b0, 0, '0));
        send_request(make_req(OP_DELAY, 6, 1'b0, 0, 64'd0));
        send_request(make_req(OP_TICK, 0, 1'b0, 0, '0));
        wait_drain();

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 36 : (phase == 1) ? 86 : 0;
            for (int n = 0; n < 530; n++) begin
                if (phase == 2 && n < 60) gap_pct = 0;
                send_request(rand_req());
                if (n == 250) wait_drain();
            end
        end

        wait_drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("priority_round_robin_task_scheduler_top regression: pass");
        end else begin
            $display("priority_round_robin_task_scheduler_top regression: fail");
        end
        $finish;
    end

endmodule

### files.f
hdl/prts_pkg.sv
hdl/prts_link_mem.sv
hdl/prts_wake_mem.sv
hdl/priority_round_robin_task_scheduler_top.sv
tb/sv/tb_priority_round_robin_task_scheduler_top.sv
